FILE: src/cds_pkg.sv
// constants and month-length lookup for the calendar date-time stepper
// no dependencies; used by cds_leap_chk and calendar_datetime_stepper_top
`default_nettype none

package cds_pkg;

	localparam int unsigned YEAR_W   = 16;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;

	localparam logic [6:0] MIN_PER_HOUR = 7'd60;
	localparam logic [6:0] SEC_PER_MIN  = 7'd60;
	localparam logic [5:0] HOUR_PER_DAY = 6'd24;
	localparam logic [4:0] MONTH_PER_YEAR = 5'd12;
	localparam logic [5:0] SECOND_MAX   = 6'd59;
	localparam logic [4:0] HOUR_MAX     = 5'd23;
	localparam logic [5:0] SECOND_STEP  = 6'd2;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	// divisibility by 25 via the multiplicative inverse mod 2^16
	localparam logic [YEAR_W-1:0] INV25      = 16'h5C29;
	localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

	typedef enum logic {
		MODE_ADD = 1'b0,
		MODE_SUB = 1'b1
	} mode_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] d;
		case (m)
			MON_FEB: d = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: src/cds_leap_chk.sv
// gregorian leap-year test, one register stage deep
// depends on cds_pkg for widths and the divide-by-25 constants
`default_nettype none

module cds_leap_chk (
	input  wire logic                       clk,
	input  wire logic [cds_pkg::YEAR_W-1:0] year,
	output logic                            leap
);

	logic [cds_pkg::YEAR_W-1:0] prod_s1;
	logic [3:0]                 low_s1;
	logic                       div25;

	always_ff @(posedge clk) begin
		prod_s1 <= cds_pkg::YEAR_W'(year * cds_pkg::INV25);
		low_s1  <= year[3:0];
	end

	// year divisible by 25 when the inverse product stays small
	assign div25 = (prod_s1 <= cds_pkg::DIV25_LIMIT);

	// divisible by 4, and not by 100 unless by 400
	assign leap = (low_s1[1:0] == 2'b00) && (!div25 || (low_s1 == 4'd0));

endmodule

`default_nettype wire

FILE: src/calendar_datetime_stepper_top.sv
// top level of the calendar date-time stepper: three-stage pipeline
// depends on cds_pkg and cds_leap_chk
//
// usage:
//   a request is taken at each rising edge with start high and busy low;
//   busy is always low, so one request can enter every cycle
//   mode 0 adds step_minutes, mode 1 subtracts it; carries and borrows run
//   through hour, day, month and year with gregorian february lengths
//   the result appears on new_* with done high for exactly one cycle,
//   once it has passed the stage 1, stage 2 and output registers;
//   throughput is one per cycle
//   stage 1 moves second, minute and hour and starts the leap test
//   (divide-by-25 product), stage 2 finishes the leap test and moves the
//   day, stage 3 moves month and year and handles underflow below year 1
//   the receiver cannot stall; results are never held back
//   reset clears the valid bits of every stage, so done stays low until
//   the first request has gone through; payload registers are not reset
`default_nettype none

module calendar_datetime_stepper_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         mode,
	input  wire logic [cds_pkg::YEAR_W-1:0]   year,
	input  wire logic [cds_pkg::MONTH_W-1:0]  month,
	input  wire logic [cds_pkg::DAY_W-1:0]    day,
	input  wire logic [cds_pkg::HOUR_W-1:0]   hour,
	input  wire logic [cds_pkg::MINUTE_W-1:0] minute,
	input  wire logic [cds_pkg::SECOND_W-1:0] second,
	input  wire logic [cds_pkg::MINUTE_W-1:0] step_minutes,
	output logic                              done,
	output logic [cds_pkg::YEAR_W-1:0]        new_year,
	output logic [cds_pkg::MONTH_W-1:0]       new_month,
	output logic [cds_pkg::DAY_W-1:0]         new_day,
	output logic [cds_pkg::HOUR_W-1:0]        new_hour,
	output logic [cds_pkg::MINUTE_W-1:0]      new_minute,
	output logic [cds_pkg::SECOND_W-1:0]      new_second
);

	localparam int unsigned YW = cds_pkg::YEAR_W;
	localparam int unsigned MW = cds_pkg::MONTH_W;
	localparam int unsigned DW = cds_pkg::DAY_W;
	localparam int unsigned HW = cds_pkg::HOUR_W;
	localparam int unsigned NW = cds_pkg::MINUTE_W;
	localparam int unsigned SW = cds_pkg::SECOND_W;

	logic accept;

	// stage 1 signals
	logic [6:0]    sec_sum;
	logic [6:0]    min_sum;
	logic [5:0]    hour_inc;
	logic [SW-1:0] sec_nx;
	logic [NW-1:0] min_nx;
	logic [HW-1:0] hour_nx;
	logic          hour_move;
	logic          day_move_nx;

	logic          valid_s1;
	cds_pkg::mode_t mode_s1;
	logic [YW-1:0] year_s1;
	logic [MW-1:0] month_s1;
	logic [DW-1:0] day_s1;
	logic [HW-1:0] hour_s1;
	logic [NW-1:0] minute_s1;
	logic [SW-1:0] second_s1;
	logic          day_move_s1;

	// stage 2 signals
	logic          leap;
	logic [MW-1:0] len_month;
	logic [DW-1:0] mlen;
	logic [DW-1:0] day_nx;
	logic          mon_move_nx;

	logic          valid_s2;
	cds_pkg::mode_t mode_s2;
	logic [YW-1:0] year_s2;
	logic [MW-1:0] month_s2;
	logic [DW-1:0] day_s2;
	logic [HW-1:0] hour_s2;
	logic [NW-1:0] minute_s2;
	logic [SW-1:0] second_s2;
	logic          mon_move_s2;

	// stage 3 signals
	logic [4:0]    mon_inc;
	logic [YW-1:0] year_nx;
	logic [MW-1:0] month_nx;
	logic [DW-1:0] day_fin;
	logic [HW-1:0] hour_fin;
	logic [NW-1:0] minute_fin;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: second, minute, hour
	always_comb begin
		sec_sum     = {1'b0, second} + {1'b0, cds_pkg::SECOND_STEP};
		min_sum     = {1'b0, minute} + {1'b0, step_minutes};
		hour_inc    = {1'b0, hour} + 6'd1;
		sec_nx      = second;
		min_nx      = minute;
		hour_nx     = hour;
		hour_move   = 1'b0;
		day_move_nx = 1'b0;
		if (cds_pkg::mode_t'(mode) == cds_pkg::MODE_ADD) begin
			sec_nx = (sec_sum < cds_pkg::SEC_PER_MIN) ? sec_sum[SW-1:0] : '0;
			if (min_sum < cds_pkg::MIN_PER_HOUR) begin
				min_nx = min_sum[NW-1:0];
			end else begin
				min_nx    = NW'(min_sum - cds_pkg::MIN_PER_HOUR);
				hour_move = 1'b1;
			end
			if (hour_move) begin
				if (hour_inc < cds_pkg::HOUR_PER_DAY) begin
					hour_nx = hour_inc[HW-1:0];
				end else begin
					hour_nx     = '0;
					day_move_nx = 1'b1;
				end
			end
		end else begin
			sec_nx = (second >= cds_pkg::SECOND_STEP) ?
				(second - cds_pkg::SECOND_STEP) : cds_pkg::SECOND_MAX;
			if (minute >= step_minutes) begin
				min_nx = minute - step_minutes;
			end else begin
				min_nx    = NW'(cds_pkg::MIN_PER_HOUR) + minute - step_minutes;
				hour_move = 1'b1;
			end
			if (hour_move) begin
				if (hour != '0) begin
					hour_nx = hour - HW'(1);
				end else begin
					hour_nx     = cds_pkg::HOUR_MAX;
					day_move_nx = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1     <= cds_pkg::mode_t'(mode);
		year_s1     <= year;
		month_s1    <= month;
		day_s1      <= day;
		hour_s1     <= hour_nx;
		minute_s1   <= min_nx;
		second_s1   <= sec_nx;
		day_move_s1 <= day_move_nx;
	end

	cds_leap_chk u_leap (
		.clk  (clk),
		.year (year),
		.leap (leap)
	);

	// stage 2: day
	always_comb begin
		len_month   = (mode_s1 == cds_pkg::MODE_ADD) ? month_s1 : (month_s1 - MW'(1));
		mlen        = cds_pkg::month_days(len_month, leap);
		day_nx      = day_s1;
		mon_move_nx = 1'b0;
		if (day_move_s1) begin
			if (mode_s1 == cds_pkg::MODE_ADD) begin
				if (day_s1 < mlen) begin
					day_nx = day_s1 + DW'(1);
				end else begin
					day_nx      = DW'(1);
					mon_move_nx = 1'b1;
				end
			end else begin
				if (day_s1 > DW'(1)) begin
					day_nx = day_s1 - DW'(1);
				end else begin
					// january and month zero wrap to december
					day_nx      = (month_s1 > cds_pkg::MON_JAN) ? mlen : DW'(31);
					mon_move_nx = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2     <= mode_s1;
		year_s2     <= year_s1;
		month_s2    <= month_s1;
		day_s2      <= day_nx;
		hour_s2     <= hour_s1;
		minute_s2   <= minute_s1;
		second_s2   <= second_s1;
		mon_move_s2 <= mon_move_nx;
	end

	// stage 3: month, year and underflow
	always_comb begin
		mon_inc    = {1'b0, month_s2} + 5'd1;
		year_nx    = year_s2;
		month_nx   = month_s2;
		day_fin    = day_s2;
		hour_fin   = hour_s2;
		minute_fin = minute_s2;
		if (mon_move_s2) begin
			if (mode_s2 == cds_pkg::MODE_ADD) begin
				if (mon_inc <= cds_pkg::MONTH_PER_YEAR) begin
					month_nx = mon_inc[MW-1:0];
				end else begin
					month_nx = cds_pkg::MON_JAN;
					year_nx  = year_s2 + YW'(1);
				end
			end else begin
				if (month_s2 > cds_pkg::MON_JAN) begin
					month_nx = month_s2 - MW'(1);
				end else if (year_s2 > YW'(1)) begin
					month_nx = cds_pkg::MON_DEC;
					year_nx  = year_s2 - YW'(1);
				end else begin
					// below year 1: clear everything but the second
					year_nx    = '0;
					month_nx   = '0;
					day_fin    = '0;
					hour_fin   = '0;
					minute_fin = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		new_year   <= year_nx;
		new_month  <= month_nx;
		new_day    <= day_fin;
		new_hour   <= hour_fin;
		new_minute <= minute_fin;
		new_second <= second_s2;
	end

endmodule

`default_nettype wire

FILE: sim/calendar_datetime_stepper_top_tb.sv
// self-checking testbench for calendar_datetime_stepper_top: a directed table, then random
// date-time requests, each checked against a typed-in expectation or an in-bench date-time predictor
// depends on cds_pkg and calendar_datetime_stepper_top
`timescale 1ns / 1ps

module calendar_datetime_stepper_top_tb;

	localparam int unsigned RANDOM_REQS = 1600;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		cds_pkg::mode_t                       mode;
		logic [cds_pkg::YEAR_W-1:0]           year;
		logic [cds_pkg::MONTH_W-1:0]          month;
		logic [cds_pkg::DAY_W-1:0]            day;
		logic [cds_pkg::HOUR_W-1:0]           hour;
		logic [cds_pkg::MINUTE_W-1:0]         minute;
		logic [cds_pkg::SECOND_W-1:0]         second;
		logic [cds_pkg::MINUTE_W-1:0]         step;
	} dt_req_t;

	typedef struct packed {
		logic [cds_pkg::YEAR_W-1:0]           year;
		logic [cds_pkg::MONTH_W-1:0]          month;
		logic [cds_pkg::DAY_W-1:0]            day;
		logic [cds_pkg::HOUR_W-1:0]           hour;
		logic [cds_pkg::MINUTE_W-1:0]         minute;
		logic [cds_pkg::SECOND_W-1:0]         second;
	} dt_res_t;

	typedef struct packed {
		dt_req_t req;
		logic    fixed;
		dt_res_t want;
	} dt_row_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic                         mode = 1'b0;
	logic [cds_pkg::YEAR_W-1:0]   year = '0;
	logic [cds_pkg::MONTH_W-1:0]  month = '0;
	logic [cds_pkg::DAY_W-1:0]    day = '0;
	logic [cds_pkg::HOUR_W-1:0]   hour = '0;
	logic [cds_pkg::MINUTE_W-1:0] minute = '0;
	logic [cds_pkg::SECOND_W-1:0] second = '0;
	logic [cds_pkg::MINUTE_W-1:0] step_minutes = '0;
	logic                         done;
	logic [cds_pkg::YEAR_W-1:0]   new_year;
	logic [cds_pkg::MONTH_W-1:0]  new_month;
	logic [cds_pkg::DAY_W-1:0]    new_day;
	logic [cds_pkg::HOUR_W-1:0]   new_hour;
	logic [cds_pkg::MINUTE_W-1:0] new_minute;
	logic [cds_pkg::SECOND_W-1:0] new_second;

	// typed-in expectation travelling with the request on the ports
	logic    tag_fixed = 1'b0;
	dt_res_t tag_want = '0;

	dt_res_t     pending_dt[$];
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;

	calendar_datetime_stepper_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.step_minutes(step_minutes),
		.done(done),
		.new_year(new_year),
		.new_month(new_month),
		.new_day(new_day),
		.new_hour(new_hour),
		.new_minute(new_minute),
		.new_second(new_second)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned month_length(input logic [cds_pkg::MONTH_W-1:0] m,
		input int unsigned y);
		bit leap;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		case (m)
			cds_pkg::MON_FEB: return leap ? 29 : 28;
			cds_pkg::MON_APR, cds_pkg::MON_JUN, cds_pkg::MON_SEP, cds_pkg::MON_NOV: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic dt_res_t step_datetime(input dt_req_t r);
		int unsigned y, mo, d, h, mi, s, st;
		dt_res_t res;
		y = 32'(r.year);
		mo = 32'(r.month);
		d = 32'(r.day);
		h = 32'(r.hour);
		mi = 32'(r.minute);
		s = 32'(r.second);
		st = 32'(r.step);
		if (r.mode == cds_pkg::MODE_ADD) begin
			s = (s + 2 < 60) ? s + 2 : 0;
			if (mi + st < 60) begin
				mi = mi + st;
			end else begin
				mi = (mi + st - 60) & 32'h3f;
				if (h + 1 < 24) begin
					h = h + 1;
				end else begin
					h = 0;
					if (d < month_length(cds_pkg::MONTH_W'(mo), y)) begin
						d = d + 1;
					end else begin
						d = 1;
						if (mo + 1 <= 12) begin
							mo = mo + 1;
						end else begin
							mo = 1;
							y = (y + 1) & 32'hffff;
						end
					end
				end
			end
		end else begin
			s = (s >= 2) ? s - 2 : 59;
			if (mi >= st) begin
				mi = mi - st;
			end else begin
				mi = (60 + mi - st) & 32'h3f;
				if (h >= 1) begin
					h = h - 1;
				end else begin
					h = 23;
					if (d > 1) begin
						d = d - 1;
					end else begin
						d = (mo > 1) ? month_length(cds_pkg::MONTH_W'(mo - 1), y) : 31;
						if (mo > 1) begin
							mo = mo - 1;
						end else begin
							mo = 12;
							if (y > 1) begin
								y = y - 1;
							end else begin
								// borrow below year 1
								y = 0;
								mo = 0;
								d = 0;
								h = 0;
								mi = 0;
							end
						end
					end
				end
			end
		end
		res.year = cds_pkg::YEAR_W'(y);
		res.month = cds_pkg::MONTH_W'(mo);
		res.day = cds_pkg::DAY_W'(d);
		res.hour = cds_pkg::HOUR_W'(h);
		res.minute = cds_pkg::MINUTE_W'(mi);
		res.second = cds_pkg::SECOND_W'(s);
		return res;
	endfunction

	function automatic dt_req_t mk_req(input cds_pkg::mode_t md, input int unsigned y, mo, d,
		h, mi, s, st);
		dt_req_t r;
		r.mode = md;
		r.year = cds_pkg::YEAR_W'(y);
		r.month = cds_pkg::MONTH_W'(mo);
		r.day = cds_pkg::DAY_W'(d);
		r.hour = cds_pkg::HOUR_W'(h);
		r.minute = cds_pkg::MINUTE_W'(mi);
		r.second = cds_pkg::SECOND_W'(s);
		r.step = cds_pkg::MINUTE_W'(st);
		return r;
	endfunction

	function automatic dt_res_t mk_res(input int unsigned y, mo, d, h, mi, s);
		dt_res_t w;
		w.year = cds_pkg::YEAR_W'(y);
		w.month = cds_pkg::MONTH_W'(mo);
		w.day = cds_pkg::DAY_W'(d);
		w.hour = cds_pkg::HOUR_W'(h);
		w.minute = cds_pkg::MINUTE_W'(mi);
		w.second = cds_pkg::SECOND_W'(s);
		return w;
	endfunction

	// mostly well-formed date-times leaning on rollover edges, some raw noise
	function automatic dt_req_t rand_request();
		dt_req_t r;
		int unsigned kind, y, mo, len;
		kind = $urandom_range(99);
		r.mode = cds_pkg::mode_t'($urandom_range(1));
		if (kind < 15) begin
			r.year = cds_pkg::YEAR_W'($urandom_range(65535));
			r.month = cds_pkg::MONTH_W'($urandom_range(15));
			r.day = cds_pkg::DAY_W'($urandom_range(31));
			r.hour = cds_pkg::HOUR_W'($urandom_range(31));
			r.minute = cds_pkg::MINUTE_W'($urandom_range(63));
			r.second = cds_pkg::SECOND_W'($urandom_range(63));
			r.step = cds_pkg::MINUTE_W'($urandom_range(63));
			return r;
		end
		case ($urandom_range(9))
			0: y = 0;
			1: y = 1;
			2: y = 2;
			3: y = 65535;
			4: begin
				case ($urandom_range(3))
					0: y = 1900;
					1: y = 2000;
					2: y = 2100;
					default: y = 2024;
				endcase
			end
			default: y = $urandom_range(65535);
		endcase
		mo = $urandom_range(12, 1);
		if (kind < 60) begin
			case ($urandom_range(3))
				0: mo = 1;
				1: mo = 12;
				2: mo = 2;
				default: ;
			endcase
		end
		len = month_length(cds_pkg::MONTH_W'(mo), y);
		r.year = cds_pkg::YEAR_W'(y);
		r.month = cds_pkg::MONTH_W'(mo);
		if (kind < 70) begin
			r.day = cds_pkg::DAY_W'($urandom_range(1) ? 1 : len);
			r.hour = cds_pkg::HOUR_W'($urandom_range(1) ? 0 : 23);
			r.minute = cds_pkg::MINUTE_W'($urandom_range(1) ? $urandom_range(59, 50) :
				$urandom_range(9));
		end else begin
			r.day = cds_pkg::DAY_W'($urandom_range(len, 1));
			r.hour = cds_pkg::HOUR_W'($urandom_range(23));
			r.minute = cds_pkg::MINUTE_W'($urandom_range(59));
		end
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(3))
				0: r.second = 0;
				1: r.second = 1;
				2: r.second = 58;
				default: r.second = 59;
			endcase
		end else begin
			r.second = cds_pkg::SECOND_W'($urandom_range(59));
		end
		r.step = cds_pkg::MINUTE_W'($urandom_range(60));
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic idle_cycles();
		while ($urandom_range(99) < 27) begin
			start <= 1'b0;
			year <= cds_pkg::YEAR_W'($urandom_range(65535));
			minute <= cds_pkg::MINUTE_W'($urandom_range(63));
			@(posedge clk);
		end
	endtask

	task automatic send_request(input dt_req_t r, input logic fixed, input dt_res_t w);
		start <= 1'b1;
		mode <= r.mode;
		year <= r.year;
		month <= r.month;
		day <= r.day;
		hour <= r.hour;
		minute <= r.minute;
		second <= r.second;
		step_minutes <= r.step;
		tag_fixed <= fixed;
		tag_want <= w;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic drain_pending();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_dt.size() != 0);
		@(posedge clk);
	endtask

	// result check and request capture, both on the edge values
	always @(posedge clk) begin : mon
		dt_res_t got, w;
		dt_req_t seen;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("calendar_datetime_stepper_top_tb: done, errors");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				got = {new_year, new_month, new_day, new_hour, new_minute, new_second};
				if (pending_dt.size() == 0) begin
					flag_mismatch($sformatf("result %p with no request pending", got));
				end else begin
					w = pending_dt.pop_front();
					if (got.year != w.year)
						flag_mismatch($sformatf("new_year %0d, want %0d", got.year, w.year));
					if (got.month != w.month)
						flag_mismatch($sformatf("new_month %0d, want %0d", got.month, w.month));
					if (got.day != w.day)
						flag_mismatch($sformatf("new_day %0d, want %0d", got.day, w.day));
					if (got.hour != w.hour)
						flag_mismatch($sformatf("new_hour %0d, want %0d", got.hour, w.hour));
					if (got.minute != w.minute)
						flag_mismatch($sformatf("new_minute %0d, want %0d", got.minute,
							w.minute));
					if (got.second != w.second)
						flag_mismatch($sformatf("new_second %0d, want %0d", got.second,
							w.second));
				end
			end
			if (start && !busy) begin
				seen = {mode, year, month, day, hour, minute, second, step_minutes};
				pending_dt.push_back(tag_fixed ? tag_want : step_datetime(seen));
			end
		end
	end

	initial begin : stim
		dt_row_t rows[$];
		dt_res_t none;
		int unsigned i;
		none = '0;

		// rollover of every field into the next year
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 12, 31, 23, 59, 58, 1), 1'b1,
			mk_res(2024, 1, 1, 0, 0, 0)});
		// borrow below year 1
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 1, 1, 1, 0, 0, 1, 1), 1'b1,
			mk_res(0, 0, 0, 0, 0, 59)});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 0, 1, 1, 0, 0, 40, 5), 1'b1,
			mk_res(0, 0, 0, 0, 0, 38)});
		// year wrap past the top
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 65535, 12, 31, 23, 59, 0, 60), 1'b1,
			mk_res(0, 1, 1, 0, 59, 2)});
		// leap rules both ways
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2024, 3, 1, 0, 0, 30, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 1900, 3, 1, 0, 0, 30, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2000, 3, 1, 0, 0, 30, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2024, 2, 28, 23, 59, 10, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2024, 2, 29, 23, 59, 10, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2100, 2, 28, 23, 59, 10, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 4, 30, 23, 30, 20, 30), 1'b0, none});
		// zero step
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 6, 15, 12, 59, 20, 0), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2023, 6, 15, 12, 0, 20, 0), 1'b0, none});
		// month codes out of range
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 0, 31, 23, 59, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 13, 31, 23, 59, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2023, 15, 1, 0, 0, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2023, 13, 1, 0, 0, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 5, 0, 1, 0, 0, 20, 1), 1'b0, none});
		// day zero, hour and minute past range
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 5, 0, 23, 59, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2023, 5, 0, 0, 0, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 5, 10, 31, 59, 20, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_ADD, 2023, 5, 10, 10, 63, 63, 63), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2023, 5, 10, 10, 0, 0, 63), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 2, 1, 1, 0, 0, 1, 1), 1'b0, none});
		rows.push_back({mk_req(cds_pkg::MODE_SUB, 65535, 15, 31, 31, 63, 63, 63), 1'b0,
			none});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			idle_cycles();
			send_request(rows[k].req, rows[k].fixed, rows[k].want);
		end
		// hold off until every directed request has come back
		drain_pending();

		for (i = 0; i < RANDOM_REQS; i++) begin
			if (i == 1000)
				drain_pending();
			if (i < 500 || i >= 800)
				idle_cycles();
			send_request(rand_request(), 1'b0, none);
		end
		drain_pending();
		repeat (10) @(posedge clk);

		if (err_cnt == 0 && pending_dt.size() == 0)
			$display("calendar_datetime_stepper_top_tb: done, clean");
		else
			$display("calendar_datetime_stepper_top_tb: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/cds_pkg.sv
src/cds_leap_chk.sv
src/calendar_datetime_stepper_top.sv
sim/calendar_datetime_stepper_top_tb.sv
